/* rtl/amtd_pkg.sv */
package amtd_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_WINDOW       = 20;
    localparam int DEF_MAX_ELEMENTS = 10;
    localparam int DEF_RUN_WIDTH    = 16;

    // Fixed widths of the result fields and of the stream data buses.
    localparam int CODE_BITS_W = 10;
    localparam int CODE_LEN_W  = 4;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // an input transfer completes this cycle
        logic ram_read;   // read the window slot at the head
        logic update;     // update sum, fill and head, write the slot, start the divide
        logic append;     // classify the mark and append the element
        logic emit;       // load the output register and clear the buffer
    } amtd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic level_change;  // the incoming sample ends the current run
        logic mark_end;      // the run that ends is a mark
        logic gap_emit;      // the gap that ends releases a character
        logic div_done;      // the average is ready this cycle
        logic out_free;      // the output register can take a result
    } amtd_status_t;

endpackage

/* rtl/amtd_ram.sv */
module amtd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 20,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/amtd_div.sv */
module amtd_div #(
    parameter int DIVIDEND_W = 21,
    parameter int DIVISOR_W  = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    trial;

    // One quotient bit per cycle, restoring form. The remainder stays below
    // the divisor, so it fits the divisor width.
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIVIDEND_W-1]};
        trial     = shifted - {1'b0, dsr_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = CNT_W'(DIVIDEND_W);
        end
        else if (cnt_reg != '0)
        begin
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_next = trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/amtd_datapath.sv */
module amtd_datapath #(
    parameter int WINDOW       = 20,
    parameter int MAX_ELEMENTS = 10,
    parameter int RUN_WIDTH    = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_wdata,
    input  logic                                sample_bit,
    input  amtd_pkg::amtd_cmd_t                 cmd,
    output amtd_pkg::amtd_status_t              status,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [amtd_pkg::CODE_BITS_W-1:0]    out_code_bits,
    output logic [amtd_pkg::CODE_LEN_W-1:0]     out_code_length,
    output logic                                out_word_end
);

    import amtd_pkg::*;

    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int HEAD_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = RUN_WIDTH + FILL_W;
    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);

    logic                 mark_level_reg;
    logic [RUN_WIDTH-1:0] run_reg;
    logic                 last_level_reg;
    logic [RUN_WIDTH-1:0] item_run_reg;
    logic                 word_reg;
    logic [HEAD_W-1:0]    head_reg;
    logic [FILL_W-1:0]    fill_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [RUN_WIDTH-1:0] avg_reg;
    logic [MAX_ELEMENTS-1:0] pattern_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 out_valid_reg;
    logic [CODE_BITS_W-1:0] out_bits_reg;
    logic [CODE_LEN_W-1:0]  out_len_reg;
    logic                 out_word_reg;

    logic [RUN_WIDTH-1:0] old_len;
    logic                 full;
    logic [SUM_W-1:0]     sum_next;
    logic [FILL_W-1:0]    fill_next;
    logic [HEAD_W-1:0]    head_next;
    logic [RUN_WIDTH+1:0] avg_x3;
    logic                 div_done;
    logic [SUM_W-1:0]     quotient;
    logic [CODE_BITS_W-1:0] bits_c;
    logic [CODE_LEN_W-1:0]  len_c;

    assign full   = (fill_reg == FILL_W'(WINDOW));
    assign avg_x3 = {1'b0, avg_reg, 1'b0} + {2'b00, avg_reg};

    assign status.level_change = (sample_bit != last_level_reg);
    assign status.mark_end     = (last_level_reg == mark_level_reg);
    assign status.gap_emit     = (count_reg != '0) && (run_reg > avg_reg);
    assign status.div_done     = div_done;
    assign status.out_free     = !out_valid_reg || out_ready;

    always_comb
    begin
        sum_next  = sum_reg + SUM_W'(item_run_reg)
                    - (full ? SUM_W'(old_len) : SUM_W'(0));
        fill_next = full ? fill_reg : fill_reg + 1'b1;
        head_next = (head_reg == HEAD_W'(WINDOW - 1)) ? '0 : head_reg + 1'b1;
    end

    amtd_ram #(
        .WIDTH (RUN_WIDTH),
        .DEPTH (WINDOW)
    ) u_window (
        .clk     (clk),
        .wr_en   (cmd.update),
        .wr_addr (head_reg),
        .wr_data (item_run_reg),
        .rd_en   (cmd.ram_read),
        .rd_addr (head_reg),
        .rd_data (old_len)
    );

    amtd_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (FILL_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.update),
        .dividend (sum_next),
        .divisor  (fill_next),
        .done     (div_done),
        .quotient (quotient)
    );

    // Result fields are cut to their widths; missing high bits read as zero.
    for (genvar i = 0; i < CODE_BITS_W; i++)
    begin : g_bits
        if (i < MAX_ELEMENTS)
        begin : g_have
            assign bits_c[i] = pattern_reg[i];
        end
        else
        begin : g_zero
            assign bits_c[i] = 1'b0;
        end
    end

    for (genvar i = 0; i < CODE_LEN_W; i++)
    begin : g_len
        if (i < CNT_W)
        begin : g_have
            assign len_c[i] = count_reg[i];
        end
        else
        begin : g_zero
            assign len_c[i] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_level_reg <= 1'b0;
            run_reg        <= '0;
            last_level_reg <= 1'b0;
            head_reg       <= '0;
            fill_reg       <= '0;
            sum_reg        <= '0;
            avg_reg        <= '0;
            pattern_reg    <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mark_level_reg <= cfg_wdata;
            end
            if (cmd.accept)
            begin
                if (status.level_change)
                begin
                    last_level_reg <= sample_bit;
                    run_reg        <= RUN_WIDTH'(1);
                end
                else if (run_reg != {RUN_WIDTH{1'b1}})
                begin
                    run_reg <= run_reg + 1'b1;
                end
            end
            if (cmd.update)
            begin
                sum_reg  <= sum_next;
                fill_reg <= fill_next;
                head_reg <= head_next;
            end
            if (div_done)
            begin
                avg_reg <= quotient[RUN_WIDTH-1:0];
            end
            if (cmd.append)
            begin
                if (count_reg < CNT_W'(MAX_ELEMENTS))
                begin
                    pattern_reg <= pattern_reg
                                   | (MAX_ELEMENTS'(item_run_reg > avg_reg) << count_reg);
                    count_reg   <= count_reg + 1'b1;
                end
                else
                begin
                    pattern_reg <= '0;
                    count_reg   <= '0;
                end
            end
            if (cmd.emit)
            begin
                pattern_reg   <= '0;
                count_reg     <= '0;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_run_reg <= run_reg;
            word_reg     <= ({2'b00, run_reg} > avg_x3);
        end
        if (cmd.emit)
        begin
            out_bits_reg <= bits_c;
            out_len_reg  <= len_c;
            out_word_reg <= word_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_code_bits   = out_bits_reg;
    assign out_code_length = out_len_reg;
    assign out_word_end    = out_word_reg;

endmodule

/* rtl/amtd_ctrl.sv */
module amtd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  amtd_pkg::amtd_status_t status,
    output amtd_pkg::amtd_cmd_t    cmd
);

    import amtd_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_READ   = 6'b000010,
        ST_UPDATE = 6'b000100,
        ST_DIVIDE = 6'b001000,
        ST_APPEND = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && status.level_change)
                begin
                    if (status.mark_end)
                    begin
                        state_next = ST_READ;
                    end
                    else if (status.gap_emit)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_READ:
            begin
                cmd.ram_read = 1'b1;
                state_next   = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (status.div_done)
                begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND:
            begin
                cmd.append = 1'b1;
                state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/adaptive_morse_timing_decoder_unit.sv */
// Adaptive Morse timing decoder.
// The slave stream takes one tone-detector sample per transfer (one timer
// tick). The block measures run lengths and keeps the average of the last
// WINDOW mark lengths. A mark longer than the average is a dash, otherwise a
// dot, and it is appended to the character buffer. A gap longer than the
// average releases the buffered character on the master stream; tlast is set
// when the gap is also longer than three averages, marking the end of a word.
// cfg_we/cfg_wdata set the detector level that counts as tone (reset: 0);
// write it only while the block is idle.
// Sequencing: a sample that continues a run or ends a gap that releases
// nothing is taken in the idle state and the block stays idle. A sample that
// ends a mark passes through a window memory read, the window update, the
// bit-serial divider that forms the average, and the append. A sample that
// releases a character waits in the emit state for a free output register.
// Results sit in an output register; while it waits for tready the block
// still takes samples, and only a second character stalls in its emit state
// until the first is taken. Reset clears the run, the window average and the
// buffer; the window memory itself is not cleared, and what is read from its
// unused slots is ignored until the window is full.
module adaptive_morse_timing_decoder_unit
#(
    parameter int WINDOW       = amtd_pkg::DEF_WINDOW,
    parameter int MAX_ELEMENTS = amtd_pkg::DEF_MAX_ELEMENTS,
    parameter int RUN_WIDTH    = amtd_pkg::DEF_RUN_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic                               cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [0] sample_bit, [7:1] zero
    input  logic [amtd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [9:0] code_bits, [13:10] code_length, [15:14] zero
    output logic [amtd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // word_end
    output logic                               m_axis_tlast
);

    import amtd_pkg::*;

    amtd_cmd_t              cmd;
    amtd_status_t           status;
    logic [CODE_BITS_W-1:0] code_bits;
    logic [CODE_LEN_W-1:0]  code_length;

    // The controller sequences each sample; the datapath holds the run, window and buffer state.
    amtd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    amtd_datapath #(
        .WINDOW       (WINDOW),
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .RUN_WIDTH    (RUN_WIDTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .sample_bit      (s_axis_tdata[0]),
        .cmd             (cmd),
        .status          (status),
        .out_ready       (m_axis_tready),
        .out_valid       (m_axis_tvalid),
        .out_code_bits   (code_bits),
        .out_code_length (code_length),
        .out_word_end    (m_axis_tlast)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - CODE_BITS_W - CODE_LEN_W)'(0), code_length, code_bits};

    // A character is only loaded when the output register can take it.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("character loaded over an untaken result");

    // A sample that ends a mark keeps the input closed for the window update.
    a_mark_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && status.level_change && status.mark_end)
        |=> !s_axis_tready)
        else $error("input open during window update");

    // The input stays closed while the average is being formed.
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> !s_axis_tready)
        else $error("input open during divide");

    // A released character holds at least one element.
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (MAX_ELEMENTS < 16)) |-> (code_length != '0))
        else $error("empty character released");

endmodule
